// ===== rtl/core/mmts_pkg.sv =====
// Shared types and constants for the maximal-munch token scanner.
// No dependencies; used by the controller, datapath and top level.
package mmts_pkg;

    localparam int TYPE_W = 5;
    localparam int LEN_W  = 5;
    localparam int POS_W  = 16;

    localparam logic [TYPE_W-1:0] TOK_END     = 5'd0;
    localparam logic [TYPE_W-1:0] TOK_UNKNOWN = 5'd1;
    localparam logic [TYPE_W-1:0] TOK_NUMBER  = 5'd2;
    localparam logic [TYPE_W-1:0] TOK_IDENT   = 5'd3;
    localparam logic [TYPE_W-1:0] TOK_WHILE   = 5'd4;
    localparam logic [TYPE_W-1:0] TOK_RET     = 5'd5;
    localparam logic [TYPE_W-1:0] TOK_VAR     = 5'd6;
    localparam logic [TYPE_W-1:0] TOK_FN      = 5'd7;
    localparam logic [TYPE_W-1:0] TOK_IF      = 5'd8;
    localparam logic [TYPE_W-1:0] TOK_LE      = 5'd9;
    localparam logic [TYPE_W-1:0] TOK_GE      = 5'd10;
    localparam logic [TYPE_W-1:0] TOK_EQ      = 5'd11;
    localparam logic [TYPE_W-1:0] TOK_SOP0    = 5'd12;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h27;

    // Index of a single-byte operator, 17 when the byte is none.
    function automatic logic [4:0] sop_index(input logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            8'h7B: r = 5'd0;   8'h7D: r = 5'd1;   8'h28: r = 5'd2;
            8'h29: r = 5'd3;   8'h3B: r = 5'd4;   8'h3D: r = 5'd5;
            8'h21: r = 5'd6;   8'h26: r = 5'd7;   8'h7C: r = 5'd8;
            8'h2D: r = 5'd9;   8'h2B: r = 5'd10;  8'h2A: r = 5'd11;
            8'h2F: r = 5'd12;  8'h3C: r = 5'd13;  8'h3E: r = 5'd14;
            8'h25: r = 5'd15;  8'h2C: r = 5'd16;
            default: r = 5'd17;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Byte consumed without entering the buffer: a carriage return, or a
    // delimiter other than a blank right after a lone quote.
    function automatic logic is_blank_chk(input logic [7:0] c, input logic qp);
        return (c == CH_CR) || (!((c == CH_SPACE) && qp) &&
               ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF)));
    endfunction

    // Controller to datapath commands.
    typedef struct packed {
        logic take_byte;   // accept byte into buffer / position counters
        logic scan_start;  // begin a rescan at position zero
        logic scan_step;   // read next byte during a rescan
        logic emit_tok;    // load output register with the finished token
        logic emit_end;    // load output register with END
        logic clear_fill;  // rescan done, empty the buffer
        logic set_last;    // output word is the last of this input
        logic newline;     // bump line, zero column after the rescan
    } mmts_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;   // token decision is final this cycle
        logic pos_end;     // current token reaches the last buffered byte
        logic fill_zero;
        logic fill_full;   // buffer holds capacity bytes
    } mmts_sts_t;

endpackage

// ===== rtl/core/mmts_ctrl.sv =====
// Controller state machine for the token scanner.
// Depends on mmts_pkg; drives mmts_dp through command and status structs.
module mmts_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    input  logic               end_of_input,
    input  logic               quote_pending,
    output logic               out_valid,
    input  logic               out_ready,
    input  mmts_pkg::mmts_sts_t sts,
    output mmts_pkg::mmts_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;

    // what to do once the rescan is complete
    localparam logic [1:0] AFT_NONE = 2'd0;
    localparam logic [1:0] AFT_END  = 2'd1;
    localparam logic [1:0] AFT_ADD  = 2'd2;
    localparam logic [1:0] AFT_NL   = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] after_reg, after_next;
    logic       ovalid_reg, ovalid_next;
    logic       scanq_reg, scanq_next;   // a rescan must follow adding the byte

    logic acc;
    logic is_blank, is_cr, quote_sp;

    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign acc       = in_valid && in_ready;
    assign is_cr     = (char_byte == mmts_pkg::CH_CR);
    assign quote_sp  = (char_byte == mmts_pkg::CH_SPACE) && quote_pending;
    assign is_blank  = !quote_sp && ((char_byte == mmts_pkg::CH_SPACE) ||
                       (char_byte == mmts_pkg::CH_TAB) || (char_byte == mmts_pkg::CH_LF));

    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        ovalid_next = ovalid_reg;
        scanq_next  = scanq_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (end_of_input)
                    begin
                        after_next = AFT_END;
                        state_next = ST_POST;
                    end
                    else if (is_cr)
                    begin
                        // zero the column and stay idle
                        cmd.take_byte = 1'b1;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                        if (is_blank)
                        begin
                            after_next = (char_byte == mmts_pkg::CH_LF) ? AFT_NL : AFT_NONE;
                            state_next = ST_POST;
                        end
                        else
                        begin
                            // byte taken now either way; if full before, rescan, then take it again; else check
                            after_next = sts.fill_full ? AFT_ADD : AFT_NONE;
                            scanq_next = !sts.fill_full;
                            state_next = ST_POST;
                        end
                    end
                end
            end
            ST_POST:
            begin
                // decide whether a rescan is needed now
                if (scanq_reg)
                begin
                    scanq_next = 1'b0;
                    if (sts.fill_full)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.fill_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    if (sts.scan_done)
                    begin
                        cmd.emit_tok = 1'b1;
                        ovalid_next  = 1'b1;
                        if (sts.pos_end)
                        begin
                            cmd.clear_fill = 1'b1;
                            cmd.set_last   = (after_reg == AFT_NONE) || (after_reg == AFT_NL);
                            state_next     = ST_OUT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    unique case (after_reg)
                        AFT_END:
                        begin
                            cmd.emit_end = 1'b1;
                            cmd.set_last = 1'b1;
                            ovalid_next  = 1'b1;
                            after_next   = AFT_NONE;
                        end
                        AFT_ADD:
                        begin
                            cmd.take_byte = 1'b1;
                            after_next    = AFT_NONE;
                            scanq_next    = 1'b1;
                            state_next    = ST_POST;
                        end
                        AFT_NL:
                        begin
                            cmd.newline = 1'b1;
                            after_next  = AFT_NONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                    if (after_reg == AFT_END || after_reg == AFT_NL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            after_reg  <= AFT_NONE;
            ovalid_reg <= 1'b0;
            scanq_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            ovalid_reg <= ovalid_next;
            scanq_reg  <= scanq_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input taken while busy");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_tok, cmd.emit_end, cmd.take_byte}))
        else $error("conflicting datapath commands");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_tok || cmd.emit_end) |-> (!ovalid_reg || out_ready))
        else $error("output overwritten");

endmodule

// ===== rtl/core/mmts_dp.sv =====
// Datapath for the token scanner: byte buffer, position counters and the
// longest-match scanner. Depends on mmts_pkg; controlled by mmts_ctrl.
module mmts_dp
#(
    parameter int BUFFER_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_byte,
    input  mmts_pkg::mmts_cmd_t cmd,
    output mmts_pkg::mmts_sts_t sts,
    output logic                quote_pending,
    output logic [4:0]          token_type,
    output logic [4:0]          token_length,
    output logic [15:0]         line_number,
    output logic [15:0]         column_number,
    output logic [7:0]          char_value,
    output logic                last
);

    localparam int CAPACITY = (BUFFER_DEPTH - 1) < 31 ? (BUFFER_DEPTH - 1) : 31;
    localparam int AW       = $clog2(BUFFER_DEPTH);
    localparam int CW       = $clog2(CAPACITY + 1);

    // matcher states, one per pattern still alive
    typedef struct packed {
        logic       num;      // valid number so far
        logic       num_sgn;  // only the sign seen
        logic       ident;
        logic       kw;       // prefix of some keyword/op still possible
        logic       quote;    // quote literal possible
    } alive_t;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   line_reg, col_reg, start_reg;
    logic [7:0]    first_reg;

    // scan state
    logic [CW-1:0] pos_reg;       // start of the current token
    logic [CW-1:0] idx_reg;       // offset of the byte being read
    logic          rd_ok_reg;     // rd_data valid for idx_reg-1
    logic [7:0]    rd_data_reg;
    logic [39:0]   txt_reg;       // first five bytes of the candidate
    alive_t        alive_reg;
    logic [4:0]    best_t_reg;
    logic [CW-1:0] best_l_reg;
    logic [7:0]    best_cv_reg;
    logic          done_reg;

    logic [4:0]  o_type_reg, o_len_reg;
    logic [15:0] o_line_reg, o_col_reg;
    logic [7:0]  o_cv_reg;
    logic        o_last_reg;

    assign token_type    = o_type_reg;
    assign token_length  = o_len_reg;
    assign line_number   = o_line_reg;
    assign column_number = o_col_reg;
    assign char_value    = o_cv_reg;
    assign last          = o_last_reg;

    assign quote_pending = (fill_reg == CW'(1)) && (first_reg == mmts_pkg::CH_QUOTE);

    // ---- incremental classifier for candidate of length ln ending in byte b
    logic [CW-1:0] ln;        // length including b
    logic [7:0]    b;
    alive_t        an;
    logic [4:0]    mt;        // match type at this length, 31 for none
    logic [7:0]    mcv;
    logic [39:0]   tn;
    logic [4:0]    sop;

    assign b  = rd_data_reg;
    assign ln = idx_reg - pos_reg;

    always_comb
    begin
        tn = txt_reg;
        if (ln <= CW'(5) && ln != '0)
        begin
            tn[(ln-CW'(1))*8 +: 8] = b;
        end
        an.num_sgn = (ln == CW'(1)) && (b == 8'h2B || b == 8'h2D);
        an.num     = mmts_pkg::is_digit(b) && ((ln == CW'(1)) || alive_reg.num
                     || alive_reg.num_sgn);
        an.ident   = (ln == CW'(1)) ? mmts_pkg::is_letter(b)
                     : alive_reg.ident && (mmts_pkg::is_letter(b) ||
                       mmts_pkg::is_digit(b) || b == 8'h5F);
        an.kw      = (ln == CW'(1)) || (alive_reg.kw && ln <= CW'(5));
        an.quote   = (ln == CW'(1)) ? (b == mmts_pkg::CH_QUOTE)
                     : (alive_reg.quote && ln <= CW'(3));
        sop        = mmts_pkg::sop_index(b);
        mt  = 5'd31;
        mcv = 8'd0;
        priority if (ln == CW'(5) && tn == {"elihw"})
            mt = mmts_pkg::TOK_WHILE;
        else if (ln == CW'(3) && an.quote && b == mmts_pkg::CH_QUOTE)
        begin
            mt  = mmts_pkg::TOK_NUMBER;
            mcv = tn[15:8];
        end
        else if (ln == CW'(3) && tn[23:0] == {"ter"})
            mt = mmts_pkg::TOK_RET;
        else if (ln == CW'(3) && tn[23:0] == {"rav"})
            mt = mmts_pkg::TOK_VAR;
        else if (ln == CW'(2) && tn[15:0] == {"nf"})
            mt = mmts_pkg::TOK_FN;
        else if (ln == CW'(2) && tn[15:0] == {"fi"})
            mt = mmts_pkg::TOK_IF;
        else if (ln == CW'(2) && tn[15:0] == {"=<"})
            mt = mmts_pkg::TOK_LE;
        else if (ln == CW'(2) && tn[15:0] == {"=>"})
            mt = mmts_pkg::TOK_GE;
        else if (ln == CW'(2) && tn[15:0] == {"=="})
            mt = mmts_pkg::TOK_EQ;
        else if (ln == CW'(1) && sop != 5'd17)
            mt = mmts_pkg::TOK_SOP0 + sop;
        else if (an.num)
            mt = mmts_pkg::TOK_NUMBER;
        else if (an.ident)
            mt = mmts_pkg::TOK_IDENT;
    end

    logic any_alive;
    assign any_alive = an.num || an.num_sgn || an.ident || an.kw || an.quote;

    // final decision for current token
    logic [4:0]    fin_t;
    logic [CW-1:0] fin_l;
    logic [7:0]    fin_cv;
    always_comb
    begin
        if (best_t_reg == 5'd31)
        begin
            fin_t  = mmts_pkg::TOK_UNKNOWN;
            fin_l  = CW'(1);
            fin_cv = 8'd0;
        end
        else
        begin
            fin_t  = best_t_reg;
            fin_l  = best_l_reg;
            fin_cv = best_cv_reg;
        end
    end

    assign sts.scan_done = done_reg;
    assign sts.pos_end   = (pos_reg + fin_l) >= fill_reg;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.fill_full = (fill_reg >= CW'(CAPACITY));

    logic [16:0] col_sum;
    assign col_sum = {1'b0, start_reg} + 17'(pos_reg);

    logic [15:0] col_inc, line_inc;
    assign col_inc  = (col_reg == 16'hFFFF) ? col_reg : col_reg + 16'd1;
    assign line_inc = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;

    // buffer write and read (read data registered)
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && !mmts_pkg::is_blank_chk(char_byte, quote_pending))
        begin
            mem[AW'(fill_reg)] <= char_byte;
        end
        rd_data_reg <= mem[AW'(idx_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
            start_reg <= '0;
            first_reg <= '0;
        end
        else
        begin
            if (cmd.take_byte && char_byte == mmts_pkg::CH_CR)
            begin
                col_reg <= '0;
            end
            else if (cmd.take_byte)
            begin
                col_reg <= col_inc;
                if (!mmts_pkg::is_blank_chk(char_byte, quote_pending))
                begin
                    if (fill_reg == '0)
                    begin
                        start_reg <= col_reg;
                        first_reg <= char_byte;
                    end
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.clear_fill)
            begin
                fill_reg <= '0;
            end
            if (cmd.newline)
            begin
                line_reg <= line_inc;
                col_reg  <= '0;
            end
        end
    end

    // scanner: one byte examined per cycle while scan steps are issued (output not stalled)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            idx_reg    <= '0;
            rd_ok_reg  <= 1'b0;
            done_reg   <= 1'b0;
            alive_reg  <= '0;
            best_t_reg <= 5'd31;
            o_last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start || (cmd.emit_tok && !sts.pos_end))
            begin
                pos_reg    <= cmd.scan_start ? '0 : pos_reg + fin_l;
                idx_reg    <= cmd.scan_start ? '0 : pos_reg + fin_l;
                rd_ok_reg  <= 1'b0;
                done_reg   <= 1'b0;
                alive_reg  <= '0;
                best_t_reg <= 5'd31;
            end
            else if (cmd.scan_step)
            begin
                if (rd_ok_reg)
                begin
                    // byte at idx_reg-1 is in rd_data_reg
                    txt_reg   <= tn;
                    alive_reg <= an;
                    if (mt != 5'd31)
                    begin
                        best_t_reg  <= mt;
                        best_l_reg  <= ln;
                        best_cv_reg <= mcv;
                    end
                    if (!any_alive || idx_reg >= fill_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                else
                begin
                    rd_ok_reg <= 1'b1;
                    idx_reg   <= idx_reg + CW'(1);
                end
            end
            if (cmd.emit_tok)
            begin
                o_type_reg <= fin_t;
                o_len_reg  <= 5'(fin_l);
                o_line_reg <= line_reg;
                o_col_reg  <= col_sum[16] ? 16'hFFFF : col_sum[15:0];
                o_cv_reg   <= fin_cv;
                o_last_reg <= cmd.set_last;
            end
            else if (cmd.emit_end)
            begin
                o_type_reg <= mmts_pkg::TOK_END;
                o_len_reg  <= '0;
                o_line_reg <= line_reg;
                o_col_reg  <= col_reg;
                o_cv_reg   <= '0;
                o_last_reg <= 1'b1;
            end
        end
    end

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("buffer overrun");
    a_pos_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_tok |-> pos_reg < fill_reg)
        else $error("token past buffer end");
    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_tok |-> (fin_l != '0))
        else $error("empty token");

endmodule

// ===== rtl/core/maximal_munch_token_scanner_unit.sv =====
// Top level of the maximal-munch token scanner: controller plus datapath.
// Depends on mmts_pkg, mmts_ctrl and mmts_dp.
// A plain byte passes through the post state back to idle; a carriage return leaves
// the controller idle. A delimiter, a byte that fills the buffer or end of input
// starts a rescan that examines buffered bytes until no pattern can still match or
// the buffer ends. END follows the last token. Stalls on output hold rescan and input.
// rst_n clears counters, fill count and control; buffer bytes are not.
module maximal_munch_token_scanner_unit
#(
    parameter int BUFFER_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_type,
    output logic [4:0]  token_length,
    output logic [15:0] line_number,
    output logic [15:0] column_number,
    output logic [7:0]  char_value,
    output logic        last
);

    mmts_pkg::mmts_cmd_t cmd;
    mmts_pkg::mmts_sts_t sts;
    logic                quote_pending;

    mmts_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_byte     (char_byte),
        .end_of_input  (end_of_input),
        .quote_pending (quote_pending),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    mmts_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_byte     (char_byte),
        .cmd           (cmd),
        .sts           (sts),
        .quote_pending (quote_pending),
        .token_type    (token_type),
        .token_length  (token_length),
        .line_number   (line_number),
        .column_number (column_number),
        .char_value    (char_value),
        .last          (last)
    );

endmodule
